/* hdl/lzfb_pkg.sv */
// Shared constants and types for the LZ flag-byte decompressor.
package lzfb_pkg;

  localparam int COUNT_BITS = 24;     // width of the produced-byte counter
  localparam int CFG_W      = 24;     // width of the output length register
  localparam int WIN_AW     = 12;     // history window address width
  localparam int WIN_DEPTH  = 1 << WIN_AW;
  localparam int RUN_W      = 13;     // token run length counter
  localparam int Q_DEPTH    = 2;      // front-to-back queue entries
  localparam int Q_AW       = $clog2(Q_DEPTH);

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [WIN_AW-1:0]     win_addr_t;
  typedef logic [RUN_W-1:0]      run_t;

  // Parser phase, one-hot.
  typedef enum logic [6:0] {
    PH_FLAG    = 7'b0000001,
    PH_LO      = 7'b0000010,
    PH_HI      = 7'b0000100,
    PH_EXTRA   = 7'b0001000,
    PH_COUNT   = 7'b0010000,
    PH_LITERAL = 7'b0100000,
    PH_COPY    = 7'b1000000
  } phase_t;

  // One classified item, handed from the parser to the history unit.
  typedef struct packed {
    logic      wr;        // item produces an output byte
    logic      from_mem;  // byte comes from the history (copy), else literal
    logic [7:0] lit;
    win_addr_t rd_addr;
    logic      rd_ok;     // history entry has been written at least once
    win_addr_t wr_addr;
    logic      want;
    logic      fin;
    logic      misuse;
  } op_t;

endpackage

/* hdl/lzfb_if.sv */
// Valid/ready channel interfaces for compressed input and decompressed results.
interface lzfb_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] in_byte;

  modport source (output valid, output func, output in_byte, input ready);
  modport sink   (input valid, input func, input in_byte, output ready);
endinterface

interface lzfb_out_if;
  logic       valid;
  logic       ready;
  logic       byte_valid;
  logic [7:0] data_byte;
  logic       want_byte;
  logic       finished;
  logic       misuse;

  modport source (output valid, output byte_valid, output data_byte, output want_byte,
                  output finished, output misuse, input ready);
  modport sink   (input valid, input byte_valid, input data_byte, input want_byte,
                  input finished, input misuse, output ready);
endinterface

/* hdl/lz_flag_byte_decompressor.sv */
// Top level of the LZ flag-byte decompressor (4 KiB history window).
//
//  channel  | dir | handshake      | payload
//  ---------+-----+----------------+-------------------------------------------
//  in_ch    | in  | valid / ready  | func, in_byte
//  out_ch   | out | valid / ready  | byte_valid, data_byte, want_byte, finished,
//           |     |                | misuse
//  cfg      | in  | cfg_we         | cfg_wdata = output_length (24 bits)
//
//  One item per cycle sustained while out_ch is ready; every transfer in yields
//  one result transfer. An input transfer writes the op queue, the op and its
//  registered RAM read then move into the read stage, and the result register
//  loads after that. The window RAM read/write pair is the per-item pacing
//  element.
//  Reset (rst_n low, synchronous) clears all control state; the window RAM is
//  not cleared, unwritten entries are masked by a fill tracker and read as 0.
//  Output stalls back up through a 2-entry op queue to in_ch.ready.
module lz_flag_byte_decompressor (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [lzfb_pkg::CFG_W-1:0] cfg_wdata,
  lzfb_in_if.sink                    in_ch,
  lzfb_out_if.source                 out_ch
);

  logic          q_push, q_full, q_pop, q_valid;
  lzfb_pkg::op_t push_op, head_op;

  // Parser: all token/flag state, write position and produced count live here,
  // so the next item is classified right away without waiting on the RAM.
  lzfb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_op      (push_op)
  );

  lzfb_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_op    (push_op),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_op    (head_op)
  );

  // History unit: registered RAM read, back-to-back forwarding, result reg.
  lzfb_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_op    (head_op),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

`ifndef SYNTHESIS
  // a result with an output byte is never a misuse result
  a_byte_not_misuse: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.byte_valid |-> !out_ch.misuse)
    else $error("output byte flagged as misuse");

  // no byte means a zero data field
  a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.byte_valid |-> out_ch.data_byte == 8'h00)
    else $error("data_byte nonzero without byte_valid");

  // once finished, no further input is requested
  a_fin_no_want: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.finished |-> !out_ch.want_byte)
    else $error("want_byte set while finished");

  // a stalled result register keeps its byte
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data_byte))
    else $error("result changed under stall");
`endif

endmodule

/* hdl/lzfb_front.sv */
// Token parser: accepts items, tracks flag/token state and positions, emits ops.
module lzfb_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [lzfb_pkg::CFG_W-1:0]   cfg_wdata,
  lzfb_in_if.sink                      in_ch,
  input  logic                         q_full,
  output logic                         q_push,
  output lzfb_pkg::op_t                q_op
);

  lzfb_pkg::phase_t    phase_r, phase_nxt, ephase;
  logic [7:0]          flag_bits_r, flag_bits_nxt, eflag;
  logic [3:0]          flags_left_r, flags_left_nxt, eleft;
  logic [15:0]         pword_r, pword_nxt, pw_hi;
  lzfb_pkg::run_t      run_r, run_nxt, run_dec, short_len, long_len;
  lzfb_pkg::win_addr_t dist_r, dist_nxt, wpos_r, wpos_nxt, rd_addr;
  logic                wrapped_r, wrapped_nxt;
  lzfb_pkg::count_t    produced_r, produced_nxt, len_c;
  logic [lzfb_pkg::CFG_W-1:0] out_len_r;
  logic                misuse, put, end_tok, fin_now;
  logic [10:0]         long_sum;

  assign len_c   = lzfb_pkg::COUNT_BITS'(out_len_r);
  assign run_dec = run_r - lzfb_pkg::RUN_W'(1);
  assign rd_addr = wpos_r - dist_r;
  assign pw_hi   = {in_ch.in_byte, pword_r[7:0]};

  // end of token: shift out one flag bit and pick the next token kind
  assign eflag  = flag_bits_r >> 1;
  assign eleft  = flags_left_r - 4'd1;
  assign ephase = (eleft == 4'd0) ? lzfb_pkg::PH_FLAG :
                  (eflag[0] ? lzfb_pkg::PH_LO : lzfb_pkg::PH_COUNT);

  assign short_len = lzfb_pkg::RUN_W'(pw_hi[2:0]) + lzfb_pkg::RUN_W'(4);
  assign long_sum  = {1'b0, pword_r[3:0], in_ch.in_byte[7:2]} + 11'd1;
  assign long_len  = {long_sum, in_ch.in_byte[1:0]};

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

  always_comb begin
    fin_now        = produced_r >= len_c;
    misuse         = fin_now || (in_ch.func != (phase_r == lzfb_pkg::PH_COPY));
    phase_nxt      = phase_r;
    flag_bits_nxt  = flag_bits_r;
    flags_left_nxt = flags_left_r;
    pword_nxt      = pword_r;
    run_nxt        = run_r;
    dist_nxt       = dist_r;
    put            = 1'b0;
    end_tok        = 1'b0;
    q_op.from_mem  = 1'b0;

    if (!misuse) begin
      if (in_ch.func) begin
        put           = 1'b1;
        q_op.from_mem = 1'b1;
        run_nxt       = run_dec;
        end_tok       = (run_dec == '0);
      end else begin
        unique case (phase_r)
          lzfb_pkg::PH_LO: begin
            pword_nxt = {8'h00, in_ch.in_byte};
            phase_nxt = lzfb_pkg::PH_HI;
          end
          lzfb_pkg::PH_HI: begin
            pword_nxt = pw_hi;
            if (pw_hi[3]) begin
              run_nxt   = short_len;
              dist_nxt  = pw_hi[15:4];
              phase_nxt = lzfb_pkg::PH_COPY;
            end else begin
              phase_nxt = lzfb_pkg::PH_EXTRA;
            end
          end
          lzfb_pkg::PH_EXTRA: begin
            run_nxt   = long_len;
            dist_nxt  = pword_r[15:4];
            phase_nxt = lzfb_pkg::PH_COPY;
          end
          lzfb_pkg::PH_COUNT: begin
            run_nxt = lzfb_pkg::RUN_W'(in_ch.in_byte);
            if (in_ch.in_byte == 8'h00) begin
              end_tok = 1'b1;
            end else begin
              phase_nxt = lzfb_pkg::PH_LITERAL;
            end
          end
          lzfb_pkg::PH_LITERAL: begin
            put     = 1'b1;
            run_nxt = run_dec;
            end_tok = (run_dec == '0);
          end
          default: begin
            // flag byte: eight tokens follow, bit 0 first
            flag_bits_nxt  = in_ch.in_byte;
            flags_left_nxt = 4'd8;
            phase_nxt      = in_ch.in_byte[0] ? lzfb_pkg::PH_LO : lzfb_pkg::PH_COUNT;
          end
        endcase
      end
    end

    if (end_tok) begin
      flag_bits_nxt  = eflag;
      flags_left_nxt = eleft;
      phase_nxt      = ephase;
    end

    wpos_nxt     = put ? wpos_r + lzfb_pkg::WIN_AW'(1) : wpos_r;
    wrapped_nxt  = wrapped_r || (put && (wpos_r == '1));
    produced_nxt = put ? produced_r + lzfb_pkg::COUNT_BITS'(1) : produced_r;

    q_op.wr      = put;
    q_op.lit     = in_ch.in_byte;
    q_op.rd_addr = rd_addr;
    // entries not yet written since reset read as zero
    q_op.rd_ok   = wrapped_r || (rd_addr < wpos_r);
    q_op.wr_addr = wpos_r;
    q_op.fin     = produced_nxt >= len_c;
    q_op.want    = !(produced_nxt >= len_c) && (phase_nxt != lzfb_pkg::PH_COPY);
    q_op.misuse  = misuse;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= lzfb_pkg::PH_FLAG;
      flag_bits_r  <= '0;
      flags_left_r <= '0;
      pword_r      <= '0;
      run_r        <= '0;
      dist_r       <= '0;
      wpos_r       <= '0;
      wrapped_r    <= 1'b0;
      produced_r   <= '0;
      out_len_r    <= '0;
    end else begin
      if (cfg_we) begin
        out_len_r <= cfg_wdata;
      end
      if (q_push) begin
        phase_r      <= phase_nxt;
        flag_bits_r  <= flag_bits_nxt;
        flags_left_r <= flags_left_nxt;
        pword_r      <= pword_nxt;
        run_r        <= run_nxt;
        dist_r       <= dist_nxt;
        wpos_r       <= wpos_nxt;
        wrapped_r    <= wrapped_nxt;
        produced_r   <= produced_nxt;
      end
    end
  end

endmodule

/* hdl/lzfb_queue.sv */
// Short op queue decoupling the parser from the history unit.
module lzfb_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  lzfb_pkg::op_t push_op,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output lzfb_pkg::op_t head_op
);

  lzfb_pkg::op_t               slot_r [lzfb_pkg::Q_DEPTH];
  logic [lzfb_pkg::Q_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [lzfb_pkg::Q_AW:0]     cnt_r;

  assign full       = (cnt_r == (lzfb_pkg::Q_AW+1)'(lzfb_pkg::Q_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_op    = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + lzfb_pkg::Q_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + lzfb_pkg::Q_AW'(1);
      end
      cnt_r <= cnt_r + (lzfb_pkg::Q_AW+1)'(push) - (lzfb_pkg::Q_AW+1)'(pop);
    end
  end

endmodule

/* hdl/lzfb_back.sv */
// History unit: window memory read, forwarding, write-back and result register.
module lzfb_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  lzfb_pkg::op_t q_op,
  output logic          q_pop,
  lzfb_out_if.source    out_ch
);

  logic [7:0]    hist [lzfb_pkg::WIN_DEPTH];
  logic [7:0]    mem_q_r, last_w_r, r_data;
  lzfb_pkg::op_t r_op_r;
  logic          r_valid_r, r_hit_r;
  logic          o_valid_r, o_free, o_load, r_adv;
  logic          o_bv_r, o_want_r, o_fin_r, o_mis_r;
  logic [7:0]    o_data_r;

  assign o_free = !o_valid_r || out_ch.ready;
  assign o_load = r_valid_r && o_free;
  assign r_adv  = !r_valid_r || o_load;
  assign q_pop  = q_valid && r_adv;

  // a read issued in the same cycle as the write of that entry sees the old
  // byte, so the byte just written is forwarded instead
  always_comb begin
    if (!r_op_r.wr) begin
      r_data = 8'h00;
    end else if (!r_op_r.from_mem) begin
      r_data = r_op_r.lit;
    end else if (r_hit_r) begin
      r_data = last_w_r;
    end else if (r_op_r.rd_ok) begin
      r_data = mem_q_r;
    end else begin
      r_data = 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      mem_q_r <= hist[q_op.rd_addr];
      r_op_r  <= q_op;
      r_hit_r <= o_load && r_op_r.wr && (r_op_r.wr_addr == q_op.rd_addr);
    end
    if (o_load && r_op_r.wr) begin
      hist[r_op_r.wr_addr] <= r_data;
      last_w_r             <= r_data;
    end
    if (o_load) begin
      o_bv_r   <= r_op_r.wr;
      o_data_r <= r_data;
      o_want_r <= r_op_r.want;
      o_fin_r  <= r_op_r.fin;
      o_mis_r  <= r_op_r.misuse;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      if (r_adv) begin
        r_valid_r <= q_valid;
      end
      if (o_free) begin
        o_valid_r <= r_valid_r;
      end
    end
  end

  assign out_ch.valid      = o_valid_r;
  assign out_ch.byte_valid = o_bv_r;
  assign out_ch.data_byte  = o_data_r;
  assign out_ch.want_byte  = o_want_r;
  assign out_ch.finished   = o_fin_r;
  assign out_ch.misuse     = o_mis_r;

endmodule
